// ===== hw/rtl/urc_pkg.sv =====
// Shared types and constants for the ultrasonic ranger controller.
package urc_pkg;

	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELOAD = 2'd2;

	localparam logic [9:0] MIN_DIST_RST = 10'd30;
	localparam logic [7:0] CLOSE_LIMIT_RST = 8'd3;
	localparam logic [12:0] RELOAD_RST = 13'd4000;
	localparam logic [31:0] PULSE_RST = 32'd2000;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	// x / 58 == (x * DIV_MULT) >> DIV_SHIFT, exact for x < 2^22
	localparam int DIV_IN_W = 22;
	localparam int DIV_SHIFT = 28;
	localparam logic [22:0] DIV_MULT = 23'd4628198;
	localparam int PROD_W = 45;
	// 58 * 65536: anything at or above saturates
	localparam logic [31:0] SAT_LIMIT = 32'd3801088;
	localparam logic [15:0] DIST_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_START = 2'd1,
		PH_HIGH = 2'd2
	} phase_t;

	typedef struct packed {
		logic opcode;
		logic echo_level;
		logic [31:0] time_us;
	} in_t;

	typedef struct packed {
		logic trigger_level;
		logic [15:0] distance_cm;
		logic path_clear;
	} out_t;

endpackage

// ===== hw/rtl/ultrasonic_ranger_control.sv =====
// Top level of the ultrasonic ranger controller: echo timing, distance and obstacle count.
// An accepted beat passes stage 1, stage 2 and the result register before it shows at the output.
// Throughput: one beat per cycle; the three stages advance together unless the output
// register holds a result that is stalled. Timing is set by the 22x23 distance multiply.
// Reset sets the control state: countdown 0, trigger low, start time 0, pulse 2000 us, valid flags low,
// close count 0, registers to 30 cm, limit 3 and reload 4000 ticks; stage data is not reset.
module ultrasonic_ranger_control (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input urc_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output urc_pkg::out_t out_data,
	input logic cfg_we,
	input logic [urc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [urc_pkg::CFG_W-1:0] cfg_wdata
);
	import urc_pkg::*;

	logic [9:0] min_dist_q;
	logic [7:0] close_limit_q;
	logic [12:0] reload_q;

	logic adv, acc, tick;
	logic trig_nxt;
	logic [31:0] start_q, pulse_q, pulse_d;

	logic v_s1, trig_s1, edge_s1;
	logic [31:0] pulse_s1;
	logic v_s2, trig_s2, edge_s2, sat_s2;
	logic [PROD_W-1:0] prod_s2;

	logic [7:0] close_q, close_d;
	logic [15:0] dist_cm;
	logic [8:0] close_inc;
	logic out_valid_q;
	out_t out_q;

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign acc = in_valid && adv;
	assign tick = acc && in_data.opcode == OP_TICK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= MIN_DIST_RST;
			close_limit_q <= CLOSE_LIMIT_RST;
			reload_q <= RELOAD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MIN_DIST: min_dist_q <= cfg_wdata[9:0];
				CFG_CLOSE_LIMIT: close_limit_q <= cfg_wdata[7:0];
				CFG_RELOAD: reload_q <= cfg_wdata[12:0];
				default: begin
				end
			endcase
		end
	end

	urc_trigger u_trigger (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.reload(reload_q),
		.level_nxt(trig_nxt)
	);

	always_comb begin
		pulse_d = pulse_q;
		if (in_data.opcode == OP_EDGE && !in_data.echo_level) begin
			pulse_d = in_data.time_us - start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			pulse_q <= PULSE_RST;
		end else if (acc && in_data.opcode == OP_EDGE) begin
			if (in_data.echo_level) begin
				start_q <= in_data.time_us;
			end
			pulse_q <= pulse_d;
		end
	end

	// stage 1: trigger level and pulse width after this beat
	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s1 <= trig_nxt;
			edge_s1 <= in_data.opcode == OP_EDGE;
			pulse_s1 <= pulse_d;
		end
	end

	// stage 2: reciprocal multiply for the divide by 58
	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s2 <= trig_s1;
			edge_s2 <= edge_s1;
			sat_s2 <= pulse_s1 >= SAT_LIMIT;
			prod_s2 <= PROD_W'(pulse_s1[DIV_IN_W-1:0]) * PROD_W'(DIV_MULT);
		end
	end

	// stage 3: distance, close counter, result register
	assign dist_cm = sat_s2 ? DIST_MAX : prod_s2[DIV_SHIFT+15:DIV_SHIFT];
	assign close_inc = {1'b0, close_q} + 9'd1;

	always_comb begin
		close_d = close_q;
		if (edge_s2) begin
			if (dist_cm < {6'd0, min_dist_q}) begin
				close_d = (close_inc > {1'b0, close_limit_q}) ? close_limit_q
					: close_inc[7:0];
			end else begin
				close_d = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.trigger_level <= trig_s2;
			out_q.distance_cm <= dist_cm;
			out_q.path_clear <= close_d < close_limit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			close_q <= '0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			out_valid_q <= v_s2;
			if (v_s2) begin
				close_q <= close_d;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted beat lost in stage 1");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && sat_s2 && adv |=> out_valid && out_data.distance_cm == DIST_MAX)
		else $error("long pulse not saturated");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s2 && adv) |=> $stable(close_q))
		else $error("close count moved without a beat");

endmodule

// ===== hw/rtl/urc_trigger.sv =====
// Tick countdown and trigger pulse generator.
module urc_trigger (
	input logic clk,
	input logic arst_n,
	input logic tick,
	input logic [12:0] reload,
	output logic level_nxt
);
	import urc_pkg::*;

	logic [13:0] cnt_q, cnt_d;
	phase_t phase_q, phase_d, phase_t1;
	logic level_q, level_d;

	always_comb begin
		cnt_d = cnt_q;
		phase_t1 = phase_q;
		phase_d = phase_q;
		level_d = level_q;
		if (tick) begin
			if (cnt_q == 14'd0) begin
				cnt_d = {1'b0, reload};
				phase_t1 = PH_START;
			end else begin
				cnt_d = cnt_q - 14'd1;
			end
			case (phase_t1)
				PH_IDLE: begin
					phase_d = PH_IDLE;
				end
				PH_START: begin
					level_d = 1'b1;
					phase_d = PH_HIGH;
				end
				default: begin
					level_d = 1'b0;
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	assign level_nxt = level_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			phase_q <= PH_IDLE;
			level_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			phase_q <= phase_d;
			level_q <= level_d;
		end
	end

	// a high trigger drops on the next tick that does not reload
	assert property (@(posedge clk) disable iff (!arst_n)
		level_q && tick && cnt_q != 14'd0 |=> !level_q)
		else $error("trigger stayed high");

	// the pulse is always high while in the high phase
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HIGH |-> level_q)
		else $error("high phase with low trigger");

	assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(cnt_q) && $stable(level_q))
		else $error("trigger state moved without a tick");

endmodule

// ===== tb/ultrasonic_ranger_control_tb.sv =====
// Testbench for the ultrasonic ranger controller: predicted readings checked against paced traffic.
module ultrasonic_ranger_control_tb;
	import urc_pkg::*;

	localparam int US_PER_CM = 58;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {
		ST_NONE,
		ST_LIGHT,
		ST_HEAVY,
		ST_PERIODIC
	} stall_mode_t;

	class ranger_scoreboard;
		logic [9:0] min_dist;
		logic [7:0] close_lim;
		logic [12:0] reload;
		logic [13:0] countdown;
		phase_t phase;
		logic trig;
		logic [31:0] start_us;
		logic [31:0] pulse_us;
		logic [7:0] close_cnt;
		out_t expected_readings[$];
		int errors;

		function new();
			min_dist = MIN_DIST_RST;
			close_lim = CLOSE_LIMIT_RST;
			reload = RELOAD_RST;
			countdown = '0;
			phase = PH_IDLE;
			trig = 1'b0;
			start_us = '0;
			pulse_us = PULSE_RST;
			close_cnt = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_MIN_DIST: min_dist = val[9:0];
				CFG_CLOSE_LIMIT: close_lim = val[7:0];
				CFG_RELOAD: reload = val;
				default: ;
			endcase
		endfunction

		function logic [15:0] distance();
			logic [31:0] q;
			q = pulse_us / US_PER_CM;
			return (q > 32'd65535) ? 16'hFFFF : q[15:0];
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction

		function void note_request(in_t b);
			out_t e;
			logic [8:0] n;
			if (b.opcode == OP_TICK) begin
				if (countdown == '0) begin
					countdown = {1'b0, reload};
					phase = PH_START;
				end else begin
					countdown = countdown - 14'd1;
				end
				case (phase)
					PH_IDLE: ;
					PH_START: begin
						trig = 1'b1;
						phase = PH_HIGH;
					end
					default: begin
						trig = 1'b0;
						phase = PH_IDLE;
					end
				endcase
			end else begin
				if (b.echo_level)
					start_us = b.time_us;
				else
					pulse_us = b.time_us - start_us;
				if (distance() < {6'd0, min_dist}) begin
					n = {1'b0, close_cnt} + 9'd1;
					close_cnt = (n > {1'b0, close_lim}) ? close_lim : n[7:0];
				end else begin
					close_cnt = '0;
				end
			end
			e.trigger_level = trig;
			e.distance_cm = distance();
			e.path_clear = (close_cnt < close_lim);
			expected_readings.push_back(e);
		endfunction

		function void check_reading(out_t got);
			out_t e;
			if (expected_readings.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected reading: trigger %0b distance %0d path_clear %0b",
						got.trigger_level, got.distance_cm, got.path_clear);
				return;
			end
			e = expected_readings.pop_front();
			if (got.trigger_level !== e.trigger_level || got.distance_cm !== e.distance_cm ||
					got.path_clear !== e.path_clear) begin
				errors++;
				if (errors <= 10)
					$display("reading mismatch: exp trigger %0b distance %0d path_clear %0b,",
						e.trigger_level, e.distance_cm, e.path_clear,
						" got trigger %0b distance %0d path_clear %0b",
						got.trigger_level, got.distance_cm, got.path_clear);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	ranger_scoreboard sb;
	int burst_left = 0;
	int beats_sent = 0;
	int stall_cycle = 0;
	stall_mode_t stall_mode = ST_NONE;

	ultrasonic_ranger_control dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		stall_cycle = stall_cycle + 1;
		if (stall_cycle % 48 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			ST_NONE: out_stall <= 1'b0;
			ST_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			ST_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_cycle % 5 < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reading(out_data);
	end

	function automatic in_t tick_beat();
		in_t b;
		b.opcode = OP_TICK;
		b.echo_level = 1'($urandom);
		b.time_us = $urandom;
		return b;
	endfunction

	function automatic in_t echo_beat(logic level, logic [31:0] t);
		in_t b;
		b.opcode = OP_EDGE;
		b.echo_level = level;
		b.time_us = t;
		return b;
	endfunction

	function automatic logic [31:0] pick_duration();
		int d;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				d = int'(sb.min_dist);
				d = d + int'($urandom_range(0, 3)) - 2;
				if (d < 0)
					d = 0;
				return d * US_PER_CM + $urandom_range(0, US_PER_CM - 1);
			end
			4, 5: return $urandom_range(0, 120000);
			6: return SAT_LIMIT - 100 + $urandom_range(0, 200);
			7: return $urandom;
			default: return $urandom_range(0, 3000);
		endcase
	endfunction

	task automatic send_beat(in_t b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		sb.note_request(b);
		beats_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_config(logic [9:0] m, logic [7:0] l, logic [12:0] r);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'($urandom);
		write_reg(CFG_MIN_DIST, {junk[12:10], m});
		write_reg(CFG_CLOSE_LIMIT, {junk[4:0], l});
		write_reg(CFG_RELOAD, r);
		write_reg(CFG_UNUSED, junk);
		cfg_we <= 1'b0;
	endtask

	task automatic echo_pulse(logic [31:0] dur);
		logic [31:0] t0;
		t0 = $urandom;
		send_beat(echo_beat(1'b1, t0));
		repeat ($urandom_range(0, 2)) send_beat(tick_beat());
		send_beat(echo_beat(1'b0, t0 + dur));
	endtask

	task automatic run_random(int n);
		int target;
		int c;
		target = beats_sent + n;
		while (beats_sent < target) begin
			c = $urandom_range(0, 9);
			if (c < 3)
				repeat ($urandom_range(1, 6)) send_beat(tick_beat());
			else if (c < 8)
				echo_pulse(pick_duration());
			else
				send_beat(echo_beat(1'($urandom), $urandom));
		end
	endtask

	initial begin
		int p;
		logic [9:0] m;
		logic [7:0] l;
		logic [12:0] r;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first ticks after reset fire the trigger
		send_beat(tick_beat());
		send_beat(tick_beat());
		send_beat(tick_beat());
		// falling edge with no rising edge, then close readings up to the limit
		send_beat(echo_beat(1'b0, 32'h0000_0000));
		send_beat(echo_beat(1'b1, 32'hFFFF_FFFF));
		send_beat(echo_beat(1'b0, 32'h0000_0100));
		send_beat(echo_beat(1'b0, 32'h0000_0200));
		send_beat(tick_beat());
		// saturation boundary
		send_beat(echo_beat(1'b1, 32'h1000_0000));
		send_beat(echo_beat(1'b0, 32'h1000_0000 + SAT_LIMIT));
		send_beat(echo_beat(1'b0, 32'h1000_0000 + SAT_LIMIT - 1));
		// wrapped duration
		send_beat(echo_beat(1'b1, 32'h8000_0000));
		send_beat(echo_beat(1'b0, 32'h7FFF_FFFF));
		// threshold boundary
		send_beat(echo_beat(1'b1, 32'hAAAA_AAAA));
		send_beat(echo_beat(1'b0, 32'hAAAA_AAAA + 30 * US_PER_CM));
		send_beat(echo_beat(1'b0, 32'hAAAA_AAAA + 30 * US_PER_CM - 1));
		send_beat(echo_beat(1'b0, 32'hAAAA_AAAA + 29 * US_PER_CM));
		send_beat(echo_beat(1'b1, 32'h5555_5555));
		send_beat(echo_beat(1'b0, 32'h5555_5555));
		send_beat(echo_beat(1'b0, 32'hFFFF_FFFF));
		drain();

		apply_config(10'd1023, 8'd255, 13'd8191);
		run_random(100);
		drain();
		// limit dropped below the running count
		apply_config(10'd1023, 8'd2, 13'd5);
		run_random(100);
		drain();
		apply_config(10'd0, 8'd0, 13'd0);
		run_random(80);
		drain();
		apply_config(10'd30, 8'd1, 13'd1);
		run_random(80);
		drain();
		for (p = 0; p < 8; p++) begin
			m = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
				: $urandom_range(0, 80));
			l = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 6));
			r = 13'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
				: $urandom_range(0, 12));
			apply_config(m, l, r);
			run_random(100);
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
